// ===== design/cple_pkg.sv =====
// Package for the circular list engine: operation and status codes,
// controller states, and the command and status bundles.
// Depends on nothing; the controller, datapath and top level import it.
package cple_pkg;

    // Width of the position field of an input word.
    localparam int POS_W = 6;

    // Operation codes carried by the func field.
    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_DUMP      = 3'd6,
        FN_CLEAR     = 3'd7
    } func_t;

    // Status codes of a result word.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_W1,
        S_INS_W2,
        S_DEL_W,
        S_DUMP,
        S_REPORT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    walk_pos;
        logic    base_tail;
        logic    rd_en;
        logic    ins_w1;
        logic    ins_w2;
        logic    set_head;
        logic    set_tail;
        logic    del_w;
        logic    clear;
        logic    out_load;
        logic    emit;
        status_t st;
    } cmd_t;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic pos_zero;
        logic pos_gt;
        logic pos_ge;
        logic pos_eq;
        logic steps_last;
        logic pend;
        logic iss_done;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

// ===== design/cple_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cple_ctrl.sv =====
// Controller of the circular list engine: decodes each input word and
// sequences walks, link writes, dumps and status reports.
// Depends on cple_pkg.
module cple_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cple_pkg::func_t  func,
    input  cple_pkg::sts_t   sts,
    output cple_pkg::cmd_t   cmd
);
    import cple_pkg::*;

    ctl_state_t state_reg, state_next;
    status_t    st_reg, st_next;
    logic       is_ins_reg, is_ins_next;
    logic       set_head_reg, set_head_next;
    logic       set_tail_reg, set_tail_next;
    logic       accept;

    // State and operation registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            st_reg       <= ST_OK;
            is_ins_reg   <= 1'b0;
            set_head_reg <= 1'b0;
            set_tail_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            st_reg       <= st_next;
            is_ins_reg   <= is_ins_next;
            set_head_reg <= set_head_next;
            set_tail_reg <= set_tail_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        is_ins_next   = is_ins_reg;
        set_head_next = set_head_reg;
        set_tail_next = set_tail_reg;
        cmd           = '0;
        cmd.st        = st_reg;
        cmd.set_head  = set_head_reg;
        cmd.set_tail  = set_tail_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_next       = ST_OK;
                    is_ins_next   = 1'b0;
                    set_head_next = 1'b0;
                    set_tail_next = 1'b0;
                    case (func)
                        FN_INS_FRONT, FN_INS_BACK:
                        begin
                            if (sts.cnt_full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.capture   = 1'b1;
                                is_ins_next   = 1'b1;
                                set_head_next = (func == FN_INS_FRONT);
                                set_tail_next = (func == FN_INS_BACK);
                                state_next    = sts.cnt_zero ? S_INS_W1 : S_WALK;
                            end
                        end
                        FN_INS_POS:
                        begin
                            if (sts.pos_gt)
                            begin
                                st_next    = ST_BAD_POS;
                                state_next = S_REPORT;
                            end
                            else if (sts.cnt_full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.capture   = 1'b1;
                                cmd.walk_pos  = !sts.pos_zero && !sts.pos_eq;
                                is_ins_next   = 1'b1;
                                set_head_next = sts.pos_zero;
                                set_tail_next = sts.pos_eq;
                                state_next    = sts.cnt_zero ? S_INS_W1 : S_WALK;
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK:
                        begin
                            if (sts.cnt_zero)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.capture   = 1'b1;
                                cmd.base_tail = (func == FN_DEL_BACK);
                                state_next    = S_WALK;
                            end
                        end
                        FN_DEL_POS:
                        begin
                            if (sts.cnt_zero)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_REPORT;
                            end
                            else if (sts.pos_ge)
                            begin
                                st_next    = ST_BAD_POS;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.capture  = 1'b1;
                                cmd.walk_pos = 1'b1;
                                state_next   = S_WALK;
                            end
                        end
                        FN_DUMP:
                        begin
                            if (sts.cnt_zero)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                cmd.capture = 1'b1;
                                state_next  = S_DUMP;
                            end
                        end
                        FN_CLEAR:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = S_REPORT;
                        end
                        default:
                        begin
                            state_next = S_REPORT;
                        end
                    endcase
                end
            end

            // One link read per cycle until the target node has been read.
            S_WALK:
            begin
                cmd.rd_en = 1'b1;
                if (sts.steps_last)
                begin
                    state_next = is_ins_reg ? S_INS_W1 : S_DEL_W;
                end
            end

            S_INS_W1:
            begin
                cmd.ins_w1 = 1'b1;
                state_next = S_INS_W2;
            end

            S_INS_W2:
            begin
                cmd.ins_w2 = 1'b1;
                state_next = S_REPORT;
            end

            S_DEL_W:
            begin
                cmd.del_w  = 1'b1;
                state_next = S_REPORT;
            end

            // Reads run one ahead of the words sent out.
            S_DUMP:
            begin
                cmd.emit  = sts.pend && sts.out_free;
                cmd.rd_en = !sts.iss_done && (!sts.pend || cmd.emit);
                if (cmd.emit && sts.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end

            S_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/cple_datapath.sv =====
// Datapath of the circular list engine: node RAMs, head, tail, count,
// free map, walk pointer, counters and the output register.
// Depends on cple_pkg and cple_ram.
module cple_datapath #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic signed [31:0]                  value,
    input  logic [cple_pkg::POS_W-1:0]          position,
    input  cple_pkg::cmd_t                      cmd,
    output cple_pkg::sts_t                      sts,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [31:0]                  element,
    output logic [4:0]                          element_index,
    output logic [5:0]                          count,
    output logic                                last
);
    import cple_pkg::*;

    localparam int SW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic [SW-1:0]         head_reg, head_next, tail_reg, tail_next;
    logic [SW-1:0]         cur_reg, cur_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         steps_reg, steps_next;
    logic [CW-1:0]         iss_reg, iss_next, idx_reg, idx_next;
    logic [CAPACITY-1:0]   free_reg, free_next;
    logic                  follow_reg, follow_next, pend_reg, pend_next;
    logic [DATA_WIDTH-1:0] val_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            status_reg;
    logic signed [31:0]    element_reg;
    logic [4:0]            index_reg;
    logic [5:0]            count_out_reg;
    logic                  last_reg;

    logic [SW-1:0]         nxt_rd, prv_rd, rd_addr, new_slot, a_slot, b_slot;
    logic [DATA_WIDTH-1:0] val_rd;
    logic                  empty;
    logic                  nxt_we, prv_we;
    logic [SW-1:0]         nxt_waddr, nxt_wdata, prv_waddr, prv_wdata;
    logic [CMPW-1:0]       pos_cmp, cnt_cmp;

    // Lowest free node.
    function automatic logic [SW-1:0] first_free(input logic [CAPACITY-1:0] map);
        logic [SW-1:0] r;
        r = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (map[i])
            begin
                r = SW'(i);
            end
        end
        return r;
    endfunction

    assign new_slot = first_free(free_reg);
    assign empty    = (count_reg == '0);
    assign rd_addr  = follow_reg ? nxt_rd : cur_reg;

    // Neighbors of a new node: the target read last and the node before it.
    assign a_slot = empty ? new_slot : prv_rd;
    assign b_slot = empty ? new_slot : cur_reg;

    // Link write ports.
    always_comb
    begin
        nxt_we    = cmd.ins_w1 || cmd.ins_w2 || cmd.del_w;
        prv_we    = nxt_we;
        nxt_waddr = new_slot;
        nxt_wdata = b_slot;
        prv_waddr = new_slot;
        prv_wdata = a_slot;
        if (cmd.ins_w2)
        begin
            nxt_waddr = a_slot;
            nxt_wdata = new_slot;
            prv_waddr = b_slot;
            prv_wdata = new_slot;
        end
        else if (cmd.del_w)
        begin
            nxt_waddr = prv_rd;
            nxt_wdata = nxt_rd;
            prv_waddr = nxt_rd;
            prv_wdata = prv_rd;
        end
    end

    cple_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (cmd.ins_w1),
        .waddr (new_slot),
        .wdata (val_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    cple_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (nxt_rd)
    );

    cple_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (prv_rd)
    );

    // List state and walk counters.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        free_next   = free_reg;
        cur_next    = cur_reg;
        steps_next  = steps_reg;
        iss_next    = iss_reg;
        idx_next    = idx_reg;
        follow_next = follow_reg;
        pend_next   = pend_reg;

        if (cmd.capture)
        begin
            cur_next    = cmd.base_tail ? tail_reg : head_reg;
            follow_next = 1'b0;
            steps_next  = cmd.walk_pos ? CW'(position) : '0;
            iss_next    = '0;
            idx_next    = '0;
            pend_next   = 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                idx_next  = idx_reg + CW'(1);
                pend_next = 1'b0;
            end
            if (cmd.rd_en)
            begin
                cur_next    = rd_addr;
                follow_next = 1'b1;
                iss_next    = iss_reg + CW'(1);
                pend_next   = 1'b1;
                if (steps_reg != '0)
                begin
                    steps_next = steps_reg - CW'(1);
                end
            end
        end

        if (cmd.ins_w2)
        begin
            if (empty || cmd.set_head)
            begin
                head_next = new_slot;
            end
            if (empty || cmd.set_tail)
            begin
                tail_next = new_slot;
            end
            free_next[new_slot] = 1'b0;
            count_next          = count_reg + CW'(1);
        end
        else if (cmd.del_w)
        begin
            if (count_reg <= CW'(1))
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                if (cur_reg == head_reg)
                begin
                    head_next = nxt_rd;
                end
                if (cur_reg == tail_reg)
                begin
                    tail_next = prv_rd;
                end
            end
            free_next[cur_reg] = 1'b1;
            count_next         = count_reg - CW'(1);
        end
        else if (cmd.clear)
        begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
            free_next  = '1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            free_reg   <= '1;
            cur_reg    <= '0;
            steps_reg  <= '0;
            iss_reg    <= '0;
            idx_reg    <= '0;
            follow_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            cur_reg    <= cur_next;
            steps_reg  <= steps_next;
            iss_reg    <= iss_next;
            idx_reg    <= idx_next;
            follow_reg <= follow_next;
            pend_reg   <= pend_next;
        end
    end

    // Value of the word being inserted.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg <= DATA_WIDTH'(value);
        end
    end

    // Flags for the controller.
    assign pos_cmp = CMPW'(position);
    assign cnt_cmp = CMPW'(count_reg);

    always_comb
    begin
        sts.cnt_zero   = empty;
        sts.cnt_full   = (count_reg == CW'(CAPACITY));
        sts.pos_zero   = (pos_cmp == '0);
        sts.pos_gt     = (pos_cmp > cnt_cmp);
        sts.pos_ge     = (pos_cmp >= cnt_cmp);
        sts.pos_eq     = (pos_cmp == cnt_cmp);
        sts.steps_last = (steps_reg == '0);
        sts.pend       = pend_reg;
        sts.iss_done   = (iss_reg == count_reg);
        sts.emit_last  = (idx_reg == count_reg - CW'(1));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load || cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg    <= cmd.st;
            element_reg   <= '0;
            index_reg     <= '0;
            count_out_reg <= 6'(count_reg);
            last_reg      <= 1'b1;
        end
        else if (cmd.emit)
        begin
            status_reg    <= ST_OK;
            element_reg   <= 32'($signed(val_rd));
            index_reg     <= 5'(idx_reg);
            count_out_reg <= 6'(count_reg);
            last_reg      <= sts.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element       = element_reg;
    assign element_index = index_reg;
    assign count         = count_out_reg;
    assign last          = last_reg;

endmodule

// ===== design/circular_positional_list_engine_unit.sv =====
// Top level of the circular list engine: controller plus datapath.
// Depends on cple_pkg, cple_ctrl, cple_datapath and cple_ram.
//
//   Channel  | Handshake             | Word
//   ---------+-----------------------+---------------------------------------
//   in       | in_valid / in_ready   | func, value, position
//   out      | out_valid / out_ready | status, element, element_index,
//            |                       | count, last
//
// A word is taken only while the controller is idle. An insert into an
// empty list skips the walk; a failed operation or a clear goes straight
// to the status report.
// The walk follows the forward link RAM, one node per cycle.
// Reset clears head, tail, count and the free map; node RAMs need no clear.
// A stalled output register holds the controller in its report or dump
// step until the word is taken.
module circular_positional_list_engine_unit #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic signed [31:0]          value,
    input  logic [cple_pkg::POS_W-1:0]  position,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic signed [31:0]          element,
    output logic [4:0]                  element_index,
    output logic [5:0]                  count,
    output logic                        last
);
    import cple_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func_t'(func)),
        .sts      (sts),
        .cmd      (cmd)
    );

    cple_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .value         (value),
        .position      (position),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .element       (element),
        .element_index (element_index),
        .count         (count),
        .last          (last)
    );

endmodule
